@@ sv/luma_contrast_depth_cue_assert.svh @@
// ----------------------------------------------------------------------------
// luma_contrast_depth_cue_assert.svh
// Assertion macros for the depth cue block. Synthesis builds see empty bodies.
// ----------------------------------------------------------------------------
`ifndef LUMA_CONTRAST_DEPTH_CUE_ASSERT_SVH
`define LUMA_CONTRAST_DEPTH_CUE_ASSERT_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define LCDC_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication
`define LCDC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define LCDC_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg)
`define LCDC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

@@ sv/lcdc_pkg.sv @@
// ----------------------------------------------------------------------------
// lcdc_pkg
// Shared constants and types of the luminance contrast depth cue block.
// ----------------------------------------------------------------------------
`default_nettype none

package lcdc_pkg;

    // frame geometry limits
    localparam int MAX_WIDTH    = 1024;
    localparam int MAX_HEIGHT   = 4096;
    localparam int COL_W        = $clog2(MAX_WIDTH);
    localparam int ROW_W        = $clog2(MAX_HEIGHT);
    localparam int WIDTH_REG_W  = COL_W + 1;
    localparam int HEIGHT_REG_W = ROW_W + 1;
    localparam int WIDTH_RESET  = 640;
    localparam int HEIGHT_RESET = 480;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = (HEIGHT_REG_W > WIDTH_REG_W) ? HEIGHT_REG_W : WIDTH_REG_W;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_COLOR  = 2'd2;

    // sample and luminance format, Q0.12
    localparam int LUMA_W     = 12;
    localparam int PROD_W     = 2 * LUMA_W;
    localparam int COEF_R     = 871;
    localparam int COEF_G     = 2929;
    localparam int COEF_B     = 296;
    localparam int LUMA_ROUND = 2048;

    // gradient and root
    localparam int GRAD_W     = LUMA_W + 1;
    localparam int SQ_TERM_W  = 2 * LUMA_W;
    localparam int SQRT_STEPS = GRAD_W;
    localparam int SQ_W       = 2 * SQRT_STEPS;
    localparam int ITER_W     = $clog2(SQRT_STEPS);
    localparam int REM_W      = SQRT_STEPS + 3;

    // depth cue scaling
    localparam int FAR_ONE  = 4096;
    localparam int ROOT_SAT = FAR_ONE / 4;
    localparam int FAR_MAX  = FAR_ONE - 1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RD0,
        ST_RD1,
        ST_RD2,
        ST_RD3,
        ST_CAP,
        ST_GRAD,
        ST_SQ,
        ST_SUM,
        ST_ROOT,
        ST_EMIT
    } state_t;

endpackage

`default_nettype wire

@@ sv/lcdc_ram.sv @@
// ----------------------------------------------------------------------------
// lcdc_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module lcdc_ram #(
    parameter int DATA_W = 12,
    parameter int DEPTH  = 1024,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              clk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [DATA_W-1:0] wr_data,
    input  wire logic              rd_en,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

@@ sv/luma_contrast_depth_cue.sv @@
// ----------------------------------------------------------------------------
// luma_contrast_depth_cue
// Streaming depth cue: per-pixel luminance, central-difference contrast over a
// clamped 3x3 cross, and a far value that falls with contrast.
//
//   channel | direction | handshake              | payload
//   --------+-----------+------------------------+------------------------------
//   in      | sink      | in_valid / in_stall    | chan_red, chan_green, chan_blue
//   out     | source    | out_valid / out_stall  | far_value, pos_x, pos_y,
//           |           |                        | frame_end, run_last
//   cfg     | sink      | cfg_en (write only)    | cfg_index, cfg_data
//
// A request makes the four reads of the row stores through their single read
// ports, then forms each result it produces (up to three) with the 13-step
// bit-pair square root, one step per cycle; a finished result waits in ST_EMIT
// while the output register is full and out_stall is high.
// Reset is asynchronous, active low; the row stores are not cleared.
// A pending result sits in the output register while the next request is taken.
// ----------------------------------------------------------------------------
`default_nettype none
`include "luma_contrast_depth_cue_assert.svh"

module luma_contrast_depth_cue (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    // configuration writes
    input  wire logic                           cfg_en,
    input  wire logic [lcdc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [lcdc_pkg::CFG_DATA_W-1:0] cfg_data,
    // pixel requests
    input  wire logic                           in_valid,
    output logic                                in_stall,
    input  wire logic [lcdc_pkg::LUMA_W-1:0]     chan_red,
    input  wire logic [lcdc_pkg::LUMA_W-1:0]     chan_green,
    input  wire logic [lcdc_pkg::LUMA_W-1:0]     chan_blue,
    // depth cue results
    output logic                                out_valid,
    input  wire logic                           out_stall,
    output logic      [lcdc_pkg::LUMA_W-1:0]     far_value,
    output logic      [lcdc_pkg::COL_W-1:0]      pos_x,
    output logic      [lcdc_pkg::ROW_W-1:0]      pos_y,
    output logic                                frame_end,
    output logic                                run_last
);

    import lcdc_pkg::*;

    // ------------------------------------------------------------------------
    // Configuration and frame position
    // ------------------------------------------------------------------------
    logic [WIDTH_REG_W-1:0]  width_reg;
    logic [HEIGHT_REG_W-1:0] height_reg;
    logic                    color_reg;
    logic [COL_W-1:0]        col_count_reg;
    logic [ROW_W-1:0]        row_count_reg;

    logic [WIDTH_REG_W-1:0]  w_eff;
    logic [HEIGHT_REG_W-1:0] h_eff;

    // Zero means one; saturate above the store size.
    always_comb
    begin
        if (width_reg == '0)
            w_eff = WIDTH_REG_W'(1);
        else if (width_reg > WIDTH_REG_W'(MAX_WIDTH))
            w_eff = WIDTH_REG_W'(MAX_WIDTH);
        else
            w_eff = width_reg;

        if (height_reg == '0)
            h_eff = HEIGHT_REG_W'(1);
        else if (height_reg > HEIGHT_REG_W'(MAX_HEIGHT))
            h_eff = HEIGHT_REG_W'(MAX_HEIGHT);
        else
            h_eff = height_reg;
    end

    // Where the incoming pixel sits in the frame.
    logic pix_last_col;
    logic pix_last_row;
    assign pix_last_col = ({1'b0, col_count_reg} + WIDTH_REG_W'(1)) == w_eff;
    assign pix_last_row = ({1'b0, row_count_reg} + HEIGHT_REG_W'(1)) == h_eff;

    // ------------------------------------------------------------------------
    // Control state
    // ------------------------------------------------------------------------
    state_t state_reg;
    state_t state_next;

    logic [2:0]        pend_reg;      // results still to form: {C, B, A}
    logic [ITER_W-1:0] iter_reg;
    logic              out_valid_reg;

    logic in_accept;
    logic out_free;
    logic out_load;

    assign in_accept = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;

    // ------------------------------------------------------------------------
    // Row stores: above holds the older row, current the newer one per column
    // ------------------------------------------------------------------------
    logic              cur_rd_en;
    logic [COL_W-1:0]  cur_rd_addr;
    logic [LUMA_W-1:0] cur_rd_data;
    logic              abv_rd_en;
    logic [COL_W-1:0]  abv_rd_addr;
    logic [LUMA_W-1:0] abv_rd_data;
    logic              row_wr_en;

    // Request copy of the pixel position and its flags.
    logic [COL_W-1:0]  c_reg;
    logic [ROW_W-1:0]  r_reg;
    logic              last_col_reg;
    logic              r_is1_reg;
    logic              h_is1_reg;

    // Luminance path.
    logic [PROD_W-1:0] prod_r_reg;
    logic [PROD_W-1:0] prod_g_reg;
    logic [PROD_W-1:0] prod_b_reg;
    logic [PROD_W-1:0] luma_sum;
    logic [LUMA_W-1:0] lum_reg;

    // Neighbors read back from the stores.
    logic [LUMA_W-1:0] cur_c_reg;    // current[c]
    logic [LUMA_W-1:0] cur_r_reg;    // current[c+1]
    logic [LUMA_W-1:0] cur_l_reg;    // current[c-1]
    logic [LUMA_W-1:0] cur_ll_reg;   // current[c-2]
    logic [LUMA_W-1:0] abv_l_reg;    // above[c-1]
    logic [LUMA_W-1:0] abv_c_reg;    // above[c]

    lcdc_ram #(
        .DATA_W (LUMA_W),
        .DEPTH  (MAX_WIDTH)
    ) u_row_above (
        .clk     (clk),
        .wr_en   (row_wr_en),
        .wr_addr (c_reg),
        .wr_data (cur_c_reg),
        .rd_en   (abv_rd_en),
        .rd_addr (abv_rd_addr),
        .rd_data (abv_rd_data)
    );

    lcdc_ram #(
        .DATA_W (LUMA_W),
        .DEPTH  (MAX_WIDTH)
    ) u_row_current (
        .clk     (clk),
        .wr_en   (row_wr_en),
        .wr_addr (c_reg),
        .wr_data (lum_reg),
        .rd_en   (cur_rd_en),
        .rd_addr (cur_rd_addr),
        .rd_data (cur_rd_data)
    );

    // ------------------------------------------------------------------------
    // Next state
    // ------------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                    state_next = ST_RD0;
            end
            ST_RD0:  state_next = ST_RD1;
            ST_RD1:  state_next = ST_RD2;
            ST_RD2:  state_next = ST_RD3;
            ST_RD3:  state_next = ST_CAP;
            ST_CAP:  state_next = (pend_reg != '0) ? ST_GRAD : ST_IDLE;
            ST_GRAD: state_next = ST_SQ;
            ST_SQ:   state_next = ST_SUM;
            ST_SUM:  state_next = ST_ROOT;
            ST_ROOT:
            begin
                if (iter_reg == '0)
                    state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (out_free)
                    state_next = (pend_reg != '0) ? ST_GRAD : ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // ------------------------------------------------------------------------
    // Control outputs: store reads, write back, handshakes
    // ------------------------------------------------------------------------
    always_comb
    begin
        in_stall    = 1'b1;
        cur_rd_en   = 1'b0;
        cur_rd_addr = c_reg;
        abv_rd_en   = 1'b0;
        abv_rd_addr = c_reg;
        row_wr_en   = 1'b0;
        out_load    = 1'b0;
        case (state_reg)
            ST_IDLE: in_stall = 1'b0;
            ST_RD0:
            begin
                cur_rd_en   = 1'b1;
                cur_rd_addr = c_reg;
                abv_rd_en   = 1'b1;
                abv_rd_addr = c_reg - COL_W'(1);
            end
            ST_RD1:
            begin
                cur_rd_en   = 1'b1;
                cur_rd_addr = c_reg + COL_W'(1);
                abv_rd_en   = 1'b1;
                abv_rd_addr = c_reg;
            end
            ST_RD2:
            begin
                cur_rd_en   = 1'b1;
                cur_rd_addr = c_reg - COL_W'(1);
            end
            ST_RD3:
            begin
                cur_rd_en   = 1'b1;
                cur_rd_addr = c_reg - COL_W'(2);
            end
            // All reads are done: shift the column down a row.
            ST_CAP:  row_wr_en = 1'b1;
            ST_EMIT: out_load  = out_free;
            default: ;
        endcase
    end

    // ------------------------------------------------------------------------
    // Control registers
    // ------------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            width_reg     <= WIDTH_REG_W'(WIDTH_RESET);
            height_reg    <= HEIGHT_REG_W'(HEIGHT_RESET);
            color_reg     <= 1'b1;
            col_count_reg <= '0;
            row_count_reg <= '0;
            pend_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            // Advance the raster position on each request.
            if (in_accept)
            begin
                pend_reg <= {pix_last_row && pix_last_col,
                             pix_last_row && (col_count_reg != '0),
                             row_count_reg != '0};
                if (pix_last_col)
                begin
                    col_count_reg <= '0;
                    row_count_reg <= pix_last_row ? '0 : row_count_reg + ROW_W'(1);
                end
                else
                begin
                    col_count_reg <= col_count_reg + COL_W'(1);
                end
            end
            else if (state_reg == ST_GRAD)
            begin
                // Drop the lowest pending result: it is being formed now.
                if (pend_reg[0])
                    pend_reg[0] <= 1'b0;
                else if (pend_reg[1])
                    pend_reg[1] <= 1'b0;
                else
                    pend_reg[2] <= 1'b0;
            end

            // Geometry writes restart the frame.
            if (cfg_en)
            begin
                case (cfg_index)
                    CFG_IDX_WIDTH:
                    begin
                        width_reg     <= cfg_data[WIDTH_REG_W-1:0];
                        col_count_reg <= '0;
                        row_count_reg <= '0;
                    end
                    CFG_IDX_HEIGHT:
                    begin
                        height_reg    <= cfg_data[HEIGHT_REG_W-1:0];
                        col_count_reg <= '0;
                        row_count_reg <= '0;
                    end
                    CFG_IDX_COLOR: color_reg <= cfg_data[0];
                    default: ;
                endcase
            end

            if (out_load)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    // ------------------------------------------------------------------------
    // Gradient, square root and depth cue datapath
    // ------------------------------------------------------------------------
    logic [LUMA_W-1:0] op_ctr;
    logic [LUMA_W-1:0] op_lf;
    logic [LUMA_W-1:0] op_rt;
    logic [LUMA_W-1:0] op_up;
    logic [LUMA_W-1:0] op_dn;
    logic [COL_W-1:0]  op_x;
    logic [ROW_W-1:0]  op_y;
    logic              op_fe;
    logic              op_last;

    logic signed [GRAD_W-1:0] gx_reg;
    logic signed [GRAD_W-1:0] gy_reg;
    logic [LUMA_W-1:0]        ctr_reg;
    logic signed [2*GRAD_W-1:0] gx_sq;
    logic signed [2*GRAD_W-1:0] gy_sq;
    logic [SQ_TERM_W-1:0]     gx2_reg;
    logic [SQ_TERM_W-1:0]     gy2_reg;
    logic [SQ_W-1:0]          sq_reg;
    logic [SQ_W-1:0]          sq_sh_reg;
    logic [REM_W-1:0]         rem_reg;
    logic [SQRT_STEPS-1:0]    root_reg;
    logic [REM_W-1:0]         rem_cat;
    logic [REM_W-1:0]         trial;
    logic [REM_W-1:0]         rem_next;
    logic [SQRT_STEPS-1:0]    root_next;

    logic [COL_W-1:0]  res_x_reg;
    logic [ROW_W-1:0]  res_y_reg;
    logic              res_fe_reg;
    logic              res_last_reg;

    logic [LUMA_W+1:0] ctr3;
    logic [LUMA_W:0]   m_val;
    logic [LUMA_W+2:0] far_sum;
    logic [LUMA_W:0]   far_q;
    logic [LUMA_W-1:0] far_sat;

    logic [LUMA_W-1:0] far_value_reg;
    logic [COL_W-1:0]  pos_x_reg;
    logic [ROW_W-1:0]  pos_y_reg;
    logic              frame_end_reg;
    logic              run_last_reg;

    assign luma_sum = prod_r_reg + prod_g_reg + prod_b_reg + PROD_W'(LUMA_ROUND);

    // Operands of the result being formed, lowest pending first:
    // A is the pixel above, B the left neighbor on the last row, C the
    // bottom right pixel. Edge neighbors clamp to the center.
    always_comb
    begin
        if (pend_reg[0])
        begin
            op_ctr  = cur_c_reg;
            op_lf   = (c_reg == '0) ? cur_c_reg : abv_l_reg;
            op_rt   = last_col_reg ? cur_c_reg : cur_r_reg;
            op_up   = r_is1_reg ? cur_c_reg : abv_c_reg;
            op_dn   = lum_reg;
            op_x    = c_reg;
            op_y    = r_reg - ROW_W'(1);
            op_fe   = 1'b0;
            op_last = (pend_reg[2:1] == '0);
        end
        else if (pend_reg[1])
        begin
            op_ctr  = cur_l_reg;
            op_lf   = (c_reg >= COL_W'(2)) ? cur_ll_reg : cur_l_reg;
            op_rt   = lum_reg;
            op_up   = h_is1_reg ? cur_l_reg : abv_l_reg;
            op_dn   = cur_l_reg;
            op_x    = c_reg - COL_W'(1);
            op_y    = r_reg;
            op_fe   = 1'b0;
            op_last = !pend_reg[2];
        end
        else
        begin
            op_ctr  = lum_reg;
            op_lf   = (c_reg != '0) ? cur_l_reg : lum_reg;
            op_rt   = lum_reg;
            // above[c] has just taken the old current[c]
            op_up   = h_is1_reg ? lum_reg : cur_c_reg;
            op_dn   = lum_reg;
            op_x    = c_reg;
            op_y    = r_reg;
            op_fe   = 1'b1;
            op_last = 1'b1;
        end
    end

    assign gx_sq = gx_reg * gx_reg;
    assign gy_sq = gy_reg * gy_reg;

    // One bit-pair step of the restoring square root.
    always_comb
    begin
        rem_cat = {rem_reg[REM_W-3:0], sq_sh_reg[SQ_W-1 -: 2]};
        trial   = {1'b0, root_reg, 2'b01};
        if (rem_cat >= trial)
        begin
            rem_next  = rem_cat - trial;
            root_next = {root_reg[SQRT_STEPS-2:0], 1'b1};
        end
        else
        begin
            rem_next  = rem_cat;
            root_next = {root_reg[SQRT_STEPS-2:0], 1'b0};
        end
    end

    // far = (3*ctr + 4096 - min(4*root, 4096)) / 4, capped at full scale
    always_comb
    begin
        ctr3 = {2'b00, ctr_reg} + {1'b0, ctr_reg, 1'b0};
        if (root_reg >= SQRT_STEPS'(ROOT_SAT))
            m_val = (LUMA_W+1)'(FAR_ONE);
        else
            m_val = {root_reg[LUMA_W-3:0], 2'b00};
        far_sum = (LUMA_W+3)'(ctr3) + (LUMA_W+3)'(FAR_ONE) - (LUMA_W+3)'(m_val);
        far_q   = far_sum[LUMA_W+2:2];
        far_sat = (far_q > (LUMA_W+1)'(FAR_MAX)) ? LUMA_W'(FAR_MAX) : far_q[LUMA_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        // Take the request: hold its position and start the luminance.
        if (in_accept)
        begin
            c_reg        <= col_count_reg;
            r_reg        <= row_count_reg;
            last_col_reg <= pix_last_col;
            r_is1_reg    <= (row_count_reg == ROW_W'(1));
            h_is1_reg    <= (h_eff == HEIGHT_REG_W'(1));
            prod_r_reg   <= PROD_W'(chan_red) * PROD_W'(COEF_R);
            prod_g_reg   <= PROD_W'(chan_green) * PROD_W'(COEF_G);
            prod_b_reg   <= PROD_W'(chan_blue) * PROD_W'(COEF_B);
            if (!color_reg)
                prod_r_reg <= {chan_red, LUMA_W'(0)};
        end

        case (state_reg)
            ST_RD0:
            begin
                if (color_reg)
                    lum_reg <= luma_sum[PROD_W-1:LUMA_W];
                else
                    lum_reg <= prod_r_reg[PROD_W-1:LUMA_W];
            end
            ST_RD1:
            begin
                cur_c_reg <= cur_rd_data;
                abv_l_reg <= abv_rd_data;
            end
            ST_RD2:
            begin
                cur_r_reg <= cur_rd_data;
                abv_c_reg <= abv_rd_data;
            end
            ST_RD3: cur_l_reg  <= cur_rd_data;
            ST_CAP: cur_ll_reg <= cur_rd_data;
            ST_GRAD:
            begin
                gx_reg       <= $signed({1'b0, op_rt}) - $signed({1'b0, op_lf});
                gy_reg       <= $signed({1'b0, op_dn}) - $signed({1'b0, op_up});
                ctr_reg      <= op_ctr;
                res_x_reg    <= op_x;
                res_y_reg    <= op_y;
                res_fe_reg   <= op_fe;
                res_last_reg <= op_last;
            end
            ST_SQ:
            begin
                gx2_reg <= gx_sq[SQ_TERM_W-1:0];
                gy2_reg <= gy_sq[SQ_TERM_W-1:0];
            end
            ST_SUM:
            begin
                sq_reg    <= SQ_W'(gx2_reg) + SQ_W'(gy2_reg);
                sq_sh_reg <= SQ_W'(gx2_reg) + SQ_W'(gy2_reg);
                rem_reg   <= '0;
                root_reg  <= '0;
                iter_reg  <= ITER_W'(SQRT_STEPS - 1);
            end
            ST_ROOT:
            begin
                rem_reg   <= rem_next;
                root_reg  <= root_next;
                sq_sh_reg <= {sq_sh_reg[SQ_W-3:0], 2'b00};
                iter_reg  <= iter_reg - ITER_W'(1);
            end
            default: ;
        endcase

        if (out_load)
        begin
            far_value_reg <= far_sat;
            pos_x_reg     <= res_x_reg;
            pos_y_reg     <= res_y_reg;
            frame_end_reg <= res_fe_reg;
            run_last_reg  <= res_last_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign far_value = far_value_reg;
    assign pos_x     = pos_x_reg;
    assign pos_y     = pos_y_reg;
    assign frame_end = frame_end_reg;
    assign run_last  = run_last_reg;

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------
    `LCDC_ASSERT_IMPL(a_col_in_frame, clk, rst_n, 1'b1, ({1'b0, col_count_reg} < w_eff), "column count beyond frame width")
    `LCDC_ASSERT_IMPL(a_idle_clean, clk, rst_n, state_reg == ST_IDLE, pend_reg == '0, "idle with results still pending")
    `LCDC_ASSERT_IMPL(a_root_exact, clk, rst_n, state_reg == ST_EMIT, ((27'(root_reg) * 27'(root_reg)) <= 27'(sq_reg)) && (((27'(root_reg) + 27'(1)) * (27'(root_reg) + 27'(1))) > 27'(sq_reg)), "square root not the floor root")
    `LCDC_ASSERT_NEXT(a_last_flagged, clk, rst_n, out_load && (pend_reg == '0), out_valid && run_last, "final result of a request lacks run_last")

endmodule

`default_nettype wire

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the luminance contrast depth cue block. A queue-fed
// driver sends pixel requests in raster order, a clocked predictor keeps its
// own copy of the two luminance rows and frame position, and a monitor checks
// every result in order. Both handshakes idle and stall at random.
// ----------------------------------------------------------------------------

module tb_top;
    import lcdc_pkg::*;

    // luminance weights and depth cue scaling, Q0.12
    localparam int unsigned RED_WEIGHT   = 871;
    localparam int unsigned GREEN_WEIGHT = 2929;
    localparam int unsigned BLUE_WEIGHT  = 296;
    localparam int unsigned LUMA_HALF    = 2048;
    localparam int unsigned CUE_ONE      = 4096;
    localparam int unsigned CUE_MAX      = 4095;
    localparam int unsigned SAMPLE_MAX   = 4095;

    // index with no register behind it
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

    // long enough for the worst request, three results, before the output stalls are counted
    localparam int SETTLE_CYCLES = 64;
    localparam int RANDOM_ITEMS  = 330;

    typedef struct packed {
        logic [LUMA_W-1:0] red;
        logic [LUMA_W-1:0] green;
        logic [LUMA_W-1:0] blue;
    } pixel_t;

    typedef struct packed {
        logic [LUMA_W-1:0] far;
        logic [COL_W-1:0]  x;
        logic [ROW_W-1:0]  y;
        logic              frame_done;
        logic              last;
    } cue_result_t;

    logic                  clk        = 1'b0;
    logic                  rst_n      = 1'b0;
    logic                  cfg_en     = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index  = '0;
    logic [CFG_DATA_W-1:0] cfg_data   = '0;
    logic                  in_valid   = 1'b0;
    logic                  in_stall;
    logic [LUMA_W-1:0]     chan_red   = '0;
    logic [LUMA_W-1:0]     chan_green = '0;
    logic [LUMA_W-1:0]     chan_blue  = '0;
    logic                  out_valid;
    logic                  out_stall  = 1'b0;
    logic [LUMA_W-1:0]     far_value;
    logic [COL_W-1:0]      pos_x;
    logic [ROW_W-1:0]      pos_y;
    logic                  frame_end;
    logic                  run_last;

    luma_contrast_depth_cue dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_en     (cfg_en),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .chan_red   (chan_red),
        .chan_green (chan_green),
        .chan_blue  (chan_blue),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .far_value  (far_value),
        .pos_x      (pos_x),
        .pos_y      (pos_y),
        .frame_end  (frame_end),
        .run_last   (run_last)
    );

    // 4 ns period
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Predictor state: register copies, the two luminance rows and the
    // position of the next incoming pixel.
    // ------------------------------------------------------------------------
    logic [WIDTH_REG_W-1:0]  width_reg  = WIDTH_RESET;
    logic [HEIGHT_REG_W-1:0] height_reg = HEIGHT_RESET;
    logic                    color_reg  = 1'b1;
    logic [LUMA_W-1:0]       luma_above [MAX_WIDTH];
    logic [LUMA_W-1:0]       luma_now   [MAX_WIDTH];
    int unsigned             next_col   = 0;
    int unsigned             next_row   = 0;

    pixel_t      pixel_req_q [$];
    cue_result_t cue_expected_q [$];
    int          mismatch_count = 0;
    bit          steady = 1'b0;     // phase runs with no idling on either side
    int          smooth_level = 2048;

    function automatic int unsigned active_width();
        if (width_reg == 0)
            return 1;
        if (width_reg > MAX_WIDTH)
            return MAX_WIDTH;
        return width_reg;
    endfunction

    function automatic int unsigned active_height();
        if (height_reg == 0)
            return 1;
        if (height_reg > MAX_HEIGHT)
            return MAX_HEIGHT;
        return height_reg;
    endfunction

    // largest root whose square fits, one bit at a time from the top
    function automatic int unsigned floor_root(int unsigned v);
        int unsigned root;
        int unsigned trial;
        root = 0;
        for (int b = 15; b >= 0; b--)
        begin
            trial = root | (32'd1 << b);
            if (trial * trial <= v)
                root = trial;
        end
        return root;
    endfunction

    function automatic logic [LUMA_W-1:0] far_cue(int ctr, int lf, int rt, int up, int dn);
        int          gx;
        int          gy;
        int unsigned mag;
        int unsigned m;
        int unsigned f;
        gx  = rt - lf;
        gy  = dn - up;
        mag = gx * gx + gy * gy;
        m   = 4 * floor_root(mag);
        if (m > CUE_ONE)
            m = CUE_ONE;
        f = (3 * ctr + CUE_ONE - m) >> 2;
        if (f > CUE_MAX)
            f = CUE_MAX;
        return f[LUMA_W-1:0];
    endfunction

    function automatic cue_result_t pack_result(logic [LUMA_W-1:0] f, int unsigned x,
                                                int unsigned y, logic done);
        cue_result_t res;
        res.far        = f;
        res.x          = x[COL_W-1:0];
        res.y          = y[ROW_W-1:0];
        res.frame_done = done;
        res.last       = 1'b0;
        return res;
    endfunction

    // Work out the results that one accepted pixel completes and advance the
    // frame position. A pixel is done once its right and lower neighbours exist.
    function automatic void predict_depth_cue(pixel_t px);
        int unsigned w, h, c, r, lum, ctr, lf, rt, up, n;
        cue_result_t batch [3];
        w = active_width();
        h = active_height();
        c = next_col;
        r = next_row;
        n = 0;
        if (color_reg)
            lum = (RED_WEIGHT * px.red + GREEN_WEIGHT * px.green + BLUE_WEIGHT * px.blue
                   + LUMA_HALF) >> 12;
        else
            lum = px.red;

        // pixel above now has its lower neighbour
        if (r >= 1)
        begin
            ctr = luma_now[c];
            lf  = (c == 0) ? ctr : luma_above[c-1];
            rt  = (c + 1 >= w) ? ctr : luma_now[c+1];
            up  = (r == 1) ? ctr : luma_above[c];
            batch[n] = pack_result(far_cue(ctr, lf, rt, up, lum), c, r - 1, 1'b0);
            n++;
        end

        luma_above[c] = luma_now[c];
        luma_now[c]   = lum[LUMA_W-1:0];

        if (r + 1 == h)
        begin
            // bottom row: left neighbour now has its right side
            if (c >= 1)
            begin
                ctr = luma_now[c-1];
                lf  = (c >= 2) ? luma_now[c-2] : ctr;
                up  = (h == 1) ? ctr : luma_above[c-1];
                batch[n] = pack_result(far_cue(ctr, lf, lum, up, ctr), c - 1, r, 1'b0);
                n++;
            end
            // bottom right closes the frame
            if (c + 1 == w)
            begin
                lf = (c >= 1) ? luma_now[c-1] : lum;
                up = (h == 1) ? lum : luma_above[c];
                batch[n] = pack_result(far_cue(lum, lf, lum, up, lum), c, r, 1'b1);
                n++;
            end
        end

        if (n > 0)
            batch[n-1].last = 1'b1;
        for (int i = 0; i < n; i++)
            cue_expected_q.push_back(batch[i]);

        c++;
        if (c >= w)
        begin
            c = 0;
            r++;
            if (r >= h)
                r = 0;
        end
        next_col = c;
        next_row = r;
    endfunction

    task automatic log_mismatch(string msg);
        if (mismatch_count < 10)
            $display("ERROR: %s", msg);
        mismatch_count++;
    endtask

    // ------------------------------------------------------------------------
    // Pixel driver: pop the next request once the previous one is taken and
    // its idle gap has run out. Predict at the edge that accepts it.
    // ------------------------------------------------------------------------
    pixel_t held_pixel;
    int     send_wait = 0;

    always @(posedge clk)
    begin : pixel_driver
        logic launch;
        pixel_t px;
        launch = 1'b0;
        if (in_valid && !in_stall)
        begin
            predict_depth_cue(held_pixel);
            send_wait = steady ? 0 : $urandom_range(0, 9);
            launch = (send_wait == 0);
        end
        else if (!in_valid)
        begin
            if (send_wait > 0)
                send_wait--;
            else
                launch = 1'b1;
        end

        if (launch && pixel_req_q.size() != 0)
        begin
            px = pixel_req_q.pop_front();
            held_pixel = px;
            chan_red   <= px.red;
            chan_green <= px.green;
            chan_blue  <= px.blue;
            in_valid   <= 1'b1;
        end
        else if (in_valid && !in_stall)
        begin
            in_valid <= 1'b0;
        end
    end

    // ------------------------------------------------------------------------
    // Result monitor: compare each taken result with the oldest expectation,
    // then hold off the next one for a random number of cycles.
    // ------------------------------------------------------------------------
    int hold_left = 0;

    always @(posedge clk)
    begin : cue_monitor
        cue_result_t want;
        if (out_valid && !out_stall)
        begin
            if (cue_expected_q.size() == 0)
            begin
                log_mismatch($sformatf("result with nothing pending: far %0d x %0d y %0d",
                                       far_value, pos_x, pos_y));
            end
            else
            begin
                want = cue_expected_q.pop_front();
                if (far_value !== want.far || pos_x !== want.x || pos_y !== want.y ||
                    frame_end !== want.frame_done || run_last !== want.last)
                    log_mismatch($sformatf({"expected far %0d x %0d y %0d end %0b last %0b,",
                                            " got far %0d x %0d y %0d end %0b last %0b"},
                                           want.far, want.x, want.y, want.frame_done,
                                           want.last, far_value, pos_x, pos_y, frame_end,
                                           run_last));
            end
            hold_left = steady ? 0 : $urandom_range(0, 9);
        end
        else if (hold_left > 0)
        begin
            hold_left--;
        end
        out_stall <= (hold_left != 0);
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------

    // Drive one register write and update the predictor copy with it; only
    // call while the block is idle.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned data);
        @(posedge clk);
        cfg_en    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data[CFG_DATA_W-1:0];
        case (idx)
            CFG_IDX_WIDTH:
            begin
                width_reg = data[WIDTH_REG_W-1:0];
                next_col  = 0;
                next_row  = 0;
            end
            CFG_IDX_HEIGHT:
            begin
                height_reg = data[HEIGHT_REG_W-1:0];
                next_col   = 0;
                next_row   = 0;
            end
            CFG_IDX_COLOR:
                color_reg = data[0];
            default:
                ;
        endcase
    endtask

    task automatic end_writes();
        @(posedge clk);
        cfg_en <= 1'b0;
    endtask

    // Wait for every request to be taken and every result to arrive, then give
    // a request that completes no pixel time to leave the pipeline.
    task automatic settle();
        do
            @(posedge clk);
        while (pixel_req_q.size() != 0 || in_valid || cue_expected_q.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic push_pixel(input logic [LUMA_W-1:0] r, input logic [LUMA_W-1:0] g,
                              input logic [LUMA_W-1:0] b);
        pixel_t px;
        px.red   = r;
        px.green = g;
        px.blue  = b;
        pixel_req_q.push_back(px);
    endtask

    // Mostly smooth drift with small noise so the contrast term spans its
    // range, mixed with fully random and saturated pixels.
    task automatic send_pixels(input int unsigned count);
        int sel;
        int ch [3];
        for (int unsigned k = 0; k < count; k++)
        begin
            sel = $urandom_range(0, 7);
            smooth_level += $urandom_range(0, 80) - 40;
            if (smooth_level < 0)
                smooth_level = 0;
            if (smooth_level > SAMPLE_MAX)
                smooth_level = SAMPLE_MAX;
            for (int i = 0; i < 3; i++)
            begin
                if (sel == 0)
                    ch[i] = $urandom_range(0, SAMPLE_MAX);
                else if (sel == 1)
                    ch[i] = $urandom_range(0, 1) ? SAMPLE_MAX : 0;
                else
                begin
                    ch[i] = smooth_level + $urandom_range(0, 16) - 8;
                    if (ch[i] < 0)
                        ch[i] = 0;
                    if (ch[i] > SAMPLE_MAX)
                        ch[i] = SAMPLE_MAX;
                end
            end
            push_pixel(ch[0], ch[1], ch[2]);
        end
    endtask

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial
    begin : stimulus
        int unsigned random_sent;
        int unsigned frame_px;
        int unsigned count;
        int unsigned split;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // Reset geometry: finish row zero and start row one so results show
        // the 640 pixel row length and the weighted luminance.
        send_pixels(WIDTH_RESET + 20);
        settle();

        // 3x3 color frame with black, white and single-channel extremes;
        // the sharp steps saturate the contrast term.
        write_reg(CFG_IDX_WIDTH, 3);
        write_reg(CFG_IDX_HEIGHT, 3);
        write_reg(CFG_IDX_COLOR, 1);
        end_writes();
        push_pixel(0, 0, 0);
        push_pixel(SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX);
        push_pixel(0, 0, 0);
        push_pixel(SAMPLE_MAX, 0, 0);
        push_pixel(0, SAMPLE_MAX, 0);
        push_pixel(0, 0, SAMPLE_MAX);
        push_pixel(SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX);
        push_pixel(2048, 2048, 2048);
        push_pixel(SAMPLE_MAX, SAMPLE_MAX, 0);
        settle();

        // Same frame in mono: green and blue carry noise that must be ignored.
        write_reg(CFG_IDX_COLOR, 0);
        write_reg(CFG_IDX_WIDTH, 3);
        end_writes();
        push_pixel(0, $urandom, $urandom);
        push_pixel(SAMPLE_MAX, $urandom, $urandom);
        push_pixel(0, $urandom, $urandom);
        push_pixel(SAMPLE_MAX, $urandom, $urandom);
        push_pixel(1, $urandom, $urandom);
        push_pixel(SAMPLE_MAX, $urandom, $urandom);
        push_pixel(4094, $urandom, $urandom);
        push_pixel(2048, $urandom, $urandom);
        push_pixel(0, $urandom, $urandom);
        settle();

        // Zero width and height fall back to a one pixel frame; the spare
        // index must not disturb anything.
        write_reg(CFG_IDX_WIDTH, 0);
        write_reg(CFG_IDX_HEIGHT, 0);
        write_reg(REG_SPARE, 13'h1FFF);
        end_writes();
        send_pixels(2);
        settle();

        // single column, then single row in color
        write_reg(CFG_IDX_WIDTH, 1);
        write_reg(CFG_IDX_HEIGHT, 4);
        end_writes();
        send_pixels(4);
        settle();
        write_reg(CFG_IDX_WIDTH, 4);
        write_reg(CFG_IDX_HEIGHT, 1);
        write_reg(CFG_IDX_COLOR, 1);
        end_writes();
        send_pixels(4);
        settle();

        // Oversized geometry saturates: a full row of MAX_WIDTH, then a full
        // column of MAX_HEIGHT, each closing its frame at the limit.
        write_reg(CFG_IDX_WIDTH, 2047);
        write_reg(CFG_IDX_HEIGHT, 1);
        end_writes();
        send_pixels(MAX_WIDTH);
        settle();
        write_reg(CFG_IDX_WIDTH, 1);
        write_reg(CFG_IDX_HEIGHT, 13'h1FFF);
        end_writes();
        send_pixels(MAX_HEIGHT);
        settle();

        // Random small frames: mostly whole frames, some cut short by the next
        // geometry write, some with a color switch in the middle of the frame.
        random_sent = 0;
        while (random_sent < RANDOM_ITEMS)
        begin
            steady = ($urandom_range(0, 3) == 0);
            write_reg(CFG_IDX_WIDTH, (($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 12))
                                     | ($urandom_range(0, 3) << WIDTH_REG_W));
            write_reg(CFG_IDX_HEIGHT, ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 6));
            if ($urandom_range(0, 1))
                write_reg(CFG_IDX_COLOR, $urandom_range(0, 1));
            if ($urandom_range(0, 7) == 0)
                write_reg(REG_SPARE, $urandom);
            end_writes();

            frame_px = active_width() * active_height();
            if ($urandom_range(0, 4) == 0)
                count = $urandom_range(1, frame_px);
            else
                count = frame_px * $urandom_range(1, 2);

            if ($urandom_range(0, 2) == 0)
            begin
                split = $urandom_range(0, count);
                send_pixels(split);
                settle();
                write_reg(CFG_IDX_COLOR, color_reg ? 0 : 1);
                end_writes();
                send_pixels(count - split);
            end
            else
            begin
                send_pixels(count);
            end
            random_sent += count;
            settle();
        end

        if (mismatch_count == 0 && cue_expected_q.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    // hard stop well past the slowest legal run
    initial
    begin : watchdog
        #(10_000_000);
        $display("FAILURE");
        $finish;
    end

endmodule
